// ----- rtl/core/srps_pkg.sv -----
// Package for the scaler ratio and phase set-up unit.
// Holds the request and result payload types, the sequencer states, the
// control structs and the 4x4 ratio code table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srps_pkg;

	localparam int DIM_W    = 12;
	localparam int FACTOR_W = 3;
	localparam int COUNT_W  = 14;
	localparam int CODE_W   = 8;
	localparam int SKIP_W   = 27;
	localparam int WEIGHT_W = 16;

	localparam logic signed [CODE_W-1:0] CODE_UP   = 8'sd100;
	localparam logic signed [CODE_W-1:0] CODE_DOWN = -8'sd100;

	localparam logic signed [CODE_W-1:0] RATIO_CODE [16] = '{
		8'sd1,  8'sd2,  8'sd3,  8'sd4,
		-8'sd2, 8'sd1,  8'sd5,  8'sd2,
		-8'sd3, -8'sd5, 8'sd1,  8'sd6,
		-8'sd4, -8'sd2, -8'sd6, 8'sd1
	};

	typedef struct packed {
		logic [DIM_W-1:0]    pic_width;
		logic [DIM_W-1:0]    pic_height;
		logic [DIM_W-1:0]    draw_width;
		logic [DIM_W-1:0]    draw_height;
		logic [FACTOR_W-1:0] h_factor;
		logic [FACTOR_W-1:0] h_factor_max;
		logic [FACTOR_W-1:0] v_factor;
		logic [FACTOR_W-1:0] v_factor_max;
		logic [DIM_W-1:0]    out_left;
		logic [DIM_W-1:0]    out_top;
		logic [DIM_W-1:0]    out_width;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0]         h_from;
		logic [COUNT_W-1:0]         h_to;
		logic [COUNT_W-1:0]         v_from;
		logic [COUNT_W-1:0]         v_to;
		logic signed [CODE_W-1:0]   h_code;
		logic signed [CODE_W-1:0]   v_code;
		logic [SKIP_W-1:0]          row_skip;
		logic [SKIP_W-1:0]          col_skip;
		logic signed [WEIGHT_W-1:0] v_weight;
		logic signed [WEIGHT_W-1:0] h_weight;
		logic [SKIP_W-1:0]          span_width;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FR, S_TO, S_MB, S_WB, S_MA, S_WA, S_QF, S_WQF, S_QT, S_WQT,
		S_P1, S_D1, S_W1, S_P2, S_D2, S_W2, S_NEXT, S_OUT
	} state_t;

	typedef struct packed {
		logic div_done;
		logic rem_zero;
		logic up;
		logic t_pos;
		logic last_axis;
	} status_t;

	typedef struct packed {
		state_t state;
		logic   div_start;
		logic   req_ready;
		logic   res_valid;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/srps_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of an unsigned dividend by an unsigned divisor.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module srps_div #(
	parameter int NW = 29,
	parameter int VW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quot,
	output logic [VW-1:0]      rem
);

	localparam int CNTW = $clog2(NW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NW-1:0]   q_q;
	logic [VW-1:0]   r_q;
	logic [VW-1:0]   d_q;
	logic [VW:0]     trial;
	logic [VW:0]     diff;

	assign trial = {r_q, q_q[NW-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[VW]) begin
				r_q <= diff[VW-1:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial[VW-1:0];
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

// ----- rtl/core/srps_ctrl.sv -----
// Sequencer of the set-up unit: steps both axes through Euclid, reduction,
// skip and weight, and the second axis also through span. Depends on srps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              res_ready,
	input  wire srps_pkg::status_t status,
	output srps_pkg::ctrl_t        ctrl
);

	import srps_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   skip_div;

	assign skip_div = status.up && !status.t_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_FR;
			S_FR:   state_d = S_TO;
			S_TO:   state_d = S_MB;
			S_MB:   state_d = S_WB;
			S_WB:   if (status.div_done) state_d = status.rem_zero ? S_QF : S_MA;
			S_MA:   state_d = S_WA;
			S_WA:   if (status.div_done) state_d = status.rem_zero ? S_QF : S_MB;
			S_QF:   state_d = S_WQF;
			S_WQF:  if (status.div_done) state_d = S_QT;
			S_QT:   state_d = S_WQT;
			S_WQT:  if (status.div_done) state_d = S_P1;
			S_P1:   state_d = S_D1;
			S_D1: begin
				if (skip_div) state_d = status.last_axis ? S_P2 : S_NEXT;
				else state_d = S_W1;
			end
			S_W1:   if (status.div_done) state_d = status.last_axis ? S_P2 : S_NEXT;
			S_P2:   state_d = S_D2;
			S_D2:   state_d = skip_div ? S_NEXT : S_W2;
			S_W2:   if (status.div_done) state_d = S_NEXT;
			S_NEXT: state_d = status.last_axis ? S_OUT : S_FR;
			S_OUT:  if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.state     = state_q;
		ctrl.req_ready = (state_q == S_IDLE);
		ctrl.res_valid = (state_q == S_OUT);
		unique case (state_q)
			S_MB, S_MA, S_QF, S_QT: ctrl.div_start = 1'b1;
			S_D1, S_D2:             ctrl.div_start = !skip_div;
			default:                ctrl.div_start = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/scaler_ratio_phase_setup_unit.sv -----
// Top level of the scaler ratio and phase set-up unit: datapath registers,
// the shared multiplier and the result register. Depends on srps_pkg,
// srps_div and srps_ctrl.
//
//  Channel | Signals                     | Direction | Payload
//  request | req_valid, req_ready, req   | in        | srps_pkg::req_t
//  result  | res_valid, res_ready, res   | out       | srps_pkg::res_t
//
// Euclid needs one division per remainder step, so the number of steps sets
// how long a request takes.
// The block takes no request while one is in work or its result waits.
// Reset clears the sequencer; a stalled result is held until taken.
`timescale 1ns / 1ps
`default_nettype none

module scaler_ratio_phase_setup_unit #(
	parameter int DIM_BITS = 12
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire srps_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_ready,
	output srps_pkg::res_t      res
);

	import srps_pkg::*;

	localparam int D  = DIM_BITS;
	localparam int CW = D + 3;
	localparam int PW = 2 * D + 4;
	localparam int NW = 2 * D + 5;
	localparam int VW = D + 4;
	localparam int XW = NW + 29;

	ctrl_t   ctrl;
	status_t status;

	req_t            req_q;
	logic            ax_q;
	logic [CW-1:0]   fr_q, to_q, ea_q, eb_q, g_q;
	logic [PW-1:0]   p_q;
	logic [NW-1:0]   n_q;
	logic [NW:0]     m_q;
	logic signed [NW:0] wt_q;
	res_t            res_q;

	logic [D-1:0]    pic_w, pic_h, drw_w, drw_h, left, top_y, wid;
	logic [FACTOR_W-1:0] hf, hm, vf, vm;
	logic [D:0]      lw;
	logic            up, t_pos;
	logic signed [CW:0] w_s;
	logic signed [NW:0] t_s;
	logic [CW-1:0]   mul_a;
	logic [D:0]      mul_b;
	logic [PW-1:0]   prod;
	logic [NW-1:0]   dvd;
	logic [VW-1:0]   dvs;
	logic            div_done;
	logic [NW-1:0]   quot;
	logic [VW-1:0]   rem;
	logic [VW-1:0]   rsel;
	logic signed [NW+1:0] span_s;

	function automatic logic [D-1:0] nz_dim(input logic [DIM_W-1:0] x);
		logic [D-1:0] v;
		v = D'(x);
		nz_dim = (v == '0) ? D'(1) : v;
	endfunction

	function automatic logic [FACTOR_W-1:0] nz_fac(input logic [FACTOR_W-1:0] x);
		nz_fac = (x == '0) ? FACTOR_W'(1) : x;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_cnt(input logic [NW:0] x);
		logic [XW-1:0] xe;
		xe = XW'(x);
		sat_cnt = (xe[XW-1:COUNT_W] != '0) ? '1 : xe[COUNT_W-1:0];
	endfunction

	function automatic logic [SKIP_W-1:0] sat_skip(input logic [NW:0] x);
		logic [XW-1:0] xe;
		xe = XW'(x);
		sat_skip = (xe[XW-1:SKIP_W] != '0) ? '1 : xe[SKIP_W-1:0];
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] sat_wt(input logic signed [NW:0] x);
		if (x > $signed((NW+1)'(32767))) sat_wt = 16'sh7fff;
		else if (x < -$signed((NW+1)'(32768))) sat_wt = 16'sh8000;
		else sat_wt = x[WEIGHT_W-1:0];
	endfunction

	function automatic logic signed [CODE_W-1:0] code_of(input logic [CW-1:0] f,
			input logic [CW-1:0] t);
		logic [1:0] fi;
		logic [1:0] ti;
		fi = 2'(f - CW'(1));
		ti = 2'(t - CW'(1));
		if (f >= CW'(1) && f <= CW'(4) && t >= CW'(1) && t <= CW'(4)) begin
			code_of = RATIO_CODE[{fi, ti}];
		end else begin
			code_of = (f <= t) ? CODE_UP : CODE_DOWN;
		end
	endfunction

	assign pic_w = nz_dim(req_q.pic_width);
	assign pic_h = nz_dim(req_q.pic_height);
	assign drw_w = nz_dim(req_q.draw_width);
	assign drw_h = nz_dim(req_q.draw_height);
	assign hf    = nz_fac(req_q.h_factor);
	assign hm    = nz_fac(req_q.h_factor_max);
	assign vf    = nz_fac(req_q.v_factor);
	assign vm    = nz_fac(req_q.v_factor_max);
	assign left  = D'(req_q.out_left);
	assign top_y = D'(req_q.out_top);
	assign wid   = D'(req_q.out_width);
	assign lw    = {1'b0, left} + {1'b0, wid};

	assign up    = to_q > fr_q;
	assign w_s   = $signed({1'b0, to_q}) - $signed({1'b0, fr_q});
	assign t_s   = $signed({1'b0, p_q, 1'b0}) - $signed({{(NW-CW){w_s[CW]}}, w_s});
	assign t_pos = !t_s[NW] && (t_s != '0);

	always_comb begin
		unique case (ctrl.state)
			S_FR: begin
				mul_a = CW'(ax_q ? hf : vf);
				mul_b = (D+1)'(ax_q ? pic_w : pic_h);
			end
			S_TO: begin
				mul_a = CW'(ax_q ? hm : vm);
				mul_b = (D+1)'(ax_q ? drw_w : drw_h);
			end
			S_P1: begin
				mul_a = fr_q;
				mul_b = (D+1)'(ax_q ? left : top_y);
			end
			default: begin
				mul_a = fr_q;
				mul_b = lw;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	always_comb begin
		unique case (ctrl.state)
			S_MB: begin
				dvd = NW'(eb_q);
				dvs = VW'(ea_q);
			end
			S_MA: begin
				dvd = NW'(ea_q);
				dvs = VW'(eb_q);
			end
			S_QF: begin
				dvd = NW'(fr_q);
				dvs = VW'(g_q);
			end
			S_QT: begin
				dvd = NW'(to_q);
				dvs = VW'(g_q);
			end
			default: begin
				dvd = up ? t_s[NW-1:0] : NW'(p_q);
				dvs = up ? {to_q, 1'b0} : VW'(to_q);
			end
		endcase
	end

	srps_div #(
		.NW(NW),
		.VW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign status.div_done  = div_done;
	assign status.rem_zero  = (rem == '0);
	assign status.up        = up;
	assign status.t_pos     = t_pos;
	assign status.last_axis = ax_q;

	srps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.res_ready (res_ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	assign rsel   = (rem == '0) ? VW'(fr_q) : rem;
	assign span_s = $signed({1'b0, m_q}) - $signed({2'b0, n_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= 1'b0;
		end else begin
			if (ctrl.state == S_IDLE) ax_q <= 1'b0;
			else if (ctrl.state == S_NEXT) ax_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.state)
			S_IDLE: if (req_valid) req_q <= req;
			S_FR: begin
				fr_q <= prod[CW-1:0];
				ea_q <= prod[CW-1:0];
			end
			S_TO: begin
				to_q <= prod[CW-1:0];
				eb_q <= prod[CW-1:0];
			end
			S_WB: begin
				if (div_done) begin
					eb_q <= rem[CW-1:0];
					g_q  <= ea_q;
				end
			end
			S_WA: begin
				if (div_done) begin
					ea_q <= rem[CW-1:0];
					g_q  <= eb_q;
				end
			end
			S_WQF: if (div_done) fr_q <= quot[CW-1:0];
			S_WQT: if (div_done) to_q <= quot[CW-1:0];
			S_P1, S_P2: p_q <= prod;
			S_D1: begin
				if (up && !t_pos) begin
					n_q  <= '0;
					wt_q <= -t_s;
				end
			end
			S_W1: begin
				if (div_done) begin
					n_q <= quot;
					if (up) wt_q <= -$signed((NW+1)'(rem));
					else wt_q <= $signed((NW+1)'(rsel)) - $signed((NW+1)'(to_q));
				end
			end
			S_D2: if (up && !t_pos) m_q <= (NW+1)'(1);
			S_W2: begin
				if (div_done) begin
					if (up) m_q <= (NW+1)'(quot) + {{NW{1'b0}}, (quot < NW'(pic_w))};
					else m_q <= (NW+1)'(quot) + {{NW{1'b0}}, (rem != '0)};
				end
			end
			S_NEXT: begin
				if (ax_q) begin
					res_q.h_from     <= sat_cnt((NW+1)'(fr_q));
					res_q.h_to       <= sat_cnt((NW+1)'(to_q));
					res_q.h_code     <= code_of(fr_q, to_q);
					res_q.col_skip   <= sat_skip((NW+1)'(n_q));
					res_q.h_weight   <= sat_wt(wt_q);
					res_q.span_width <= span_s[NW+1] ? '0 : sat_skip(span_s[NW:0]);
				end else begin
					res_q.v_from   <= sat_cnt((NW+1)'(fr_q));
					res_q.v_to     <= sat_cnt((NW+1)'(to_q));
					res_q.v_code   <= code_of(fr_q, to_q);
					res_q.row_skip <= sat_skip((NW+1)'(n_q));
					res_q.v_weight <= sat_wt(wt_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign req_ready = ctrl.req_ready;
	assign res_valid = ctrl.res_valid;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/srps_checker.sv -----
// Port-level checks of the scaler ratio and phase set-up unit, bound to the
// top level. Depends on srps_pkg and scaler_ratio_phase_setup_unit.
`timescale 1ns / 1ps
`default_nettype none

module srps_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire srps_pkg::res_t res
);

	import srps_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && res_valid))
		else $error("request taken while a result waits");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready && !res_valid)
		else $error("block not busy after taking a request");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.h_code >= CODE_DOWN && res.h_code <= CODE_UP
			&& res.v_code >= CODE_DOWN && res.v_code <= CODE_UP)
		else $error("filter code out of range");

endmodule

bind scaler_ratio_phase_setup_unit srps_checker u_srps_checker (.*);

`default_nettype wire
